@@ hw/rtl/spline_tangent_estimator_core_macros.svh @@
// assertion helpers, clocked on clk and held off while arst_n is low
`ifndef SPLINE_TANGENT_ESTIMATOR_CORE_MACROS_SVH
`define SPLINE_TANGENT_ESTIMATOR_CORE_MACROS_SVH

`define STE_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define STE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/ste_pkg.sv @@
package ste_pkg;

	localparam int CoordW    = 32;
	localparam int DiffW     = CoordW + 1;
	localparam int ScaleW    = 16;
	localparam int ScaleFrac = 8;
	localparam int IdxOutW   = 16;
	localparam int MaxPoints = 65536;
	localparam int CfgDataW  = 32;
	localparam int AddrW     = 3;

	localparam int SumW  = 2 * DiffW + 2;
	localparam int RootW = SumW / 2 + 2;
	localparam int MulAW = SumW;
	localparam int MulBW = RootW;
	localparam int ProdW = MulAW + ScaleW + 2;
	localparam int NumW  = ProdW;
	localparam int DenW  = RootW + ScaleFrac + 1;
	localparam int QW    = CoordW + 1;

	localparam logic [CoordW-1:0] TanMax = {1'b0, {(CoordW-1){1'b1}}};
	localparam logic [CoordW-1:0] TanMin = {1'b1, {(CoordW-1){1'b0}}};
	localparam logic [ScaleW-1:0] ScaleReset = ScaleW'(256);
	localparam logic [1:0] CompLast = 2'd2;

	localparam logic RegClosed = 1'b0;
	localparam logic RegScale  = 1'b1;

	typedef logic [2:0][CoordW-1:0] coord_vec_t;
	typedef logic [2:0][DiffW-1:0] diff_vec_t;

	typedef struct packed {
		logic signed [CoordW-1:0] pos_x;
		logic signed [CoordW-1:0] pos_y;
		logic signed [CoordW-1:0] pos_z;
		logic last_point;
	} pt_req_t;

	typedef struct packed {
		logic [IdxOutW-1:0] point_index;
		logic signed [CoordW-1:0] in_tan_x;
		logic signed [CoordW-1:0] in_tan_y;
		logic signed [CoordW-1:0] in_tan_z;
		logic signed [CoordW-1:0] out_tan_x;
		logic signed [CoordW-1:0] out_tan_y;
		logic signed [CoordW-1:0] out_tan_z;
		logic run_done;
	} tan_res_t;

	localparam int JobCount = 6;

	typedef enum logic [2:0] {
		JOB_INT,
		JOB_LONE,
		JOB_CW1,
		JOB_CW2,
		JOB_OPEN0,
		JOB_OPENE
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PICK,
		ST_IN_GO,
		ST_IN_WAIT,
		ST_OUT_GO,
		ST_OUT_WAIT,
		ST_EMIT,
		ST_UPDATE
	} core_state_t;

	typedef enum logic [3:0] {
		TS_IDLE,
		TS_SQ_GO,
		TS_SQ_WAIT,
		TS_RT_GO,
		TS_RT_WAIT,
		TS_MA_GO,
		TS_MA_WAIT,
		TS_MS_GO,
		TS_MS_WAIT,
		TS_DV_GO,
		TS_DV_WAIT,
		TS_DONE
	} tan_state_t;

endpackage

@@ hw/rtl/ste_mul.sv @@
module ste_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ste_pkg::MulAW-1:0] a,
	input  logic [ste_pkg::MulBW-1:0] b,
	output logic done,
	output logic [ste_pkg::ProdW-1:0] prod
);
	import ste_pkg::*;

	localparam int CntW = $clog2(MulBW + 1);

	logic [MulAW-1:0] a_q;
	logic [MulBW-1:0] b_q;
	logic [ProdW-1:0] acc_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CntW'(MulBW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CntW'(1));
			done_q <= (cnt_q == CntW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// msb-first shift and add, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[ProdW-2:0], 1'b0} + (b_q[MulBW-1] ? ProdW'(a_q) : '0);
			b_q   <= {b_q[MulBW-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ hw/rtl/ste_sqrt.sv @@
module ste_sqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [2*ste_pkg::RootW-1:0] s,
	output logic done,
	output logic [ste_pkg::RootW-1:0] root
);
	import ste_pkg::*;

	localparam int CntW = $clog2(RootW + 1);

	logic [2*RootW-1:0] s_q;
	logic [RootW+1:0] rem_q;
	logic [RootW-1:0] root_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [RootW+1:0] r2;
	logic [RootW+1:0] trial;
	logic ge;

	// one root bit per cycle, two radicand bits shifted in
	assign r2    = {rem_q[RootW-1:0], s_q[2*RootW-1 -: 2]};
	assign trial = {root_q, 2'b01};
	assign ge    = (r2 >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CntW'(RootW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CntW'(1));
			done_q <= (cnt_q == CntW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			s_q    <= s;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			s_q    <= {s_q[2*RootW-3:0], 2'b00};
			rem_q  <= ge ? (r2 - trial) : r2;
			root_q <= {root_q[RootW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ hw/rtl/ste_div.sv @@
module ste_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ste_pkg::NumW-1:0] n,
	input  logic [ste_pkg::DenW-1:0] d,
	output logic done,
	output logic [ste_pkg::QW-1:0] q,
	output logic ovf
);
	import ste_pkg::*;

	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] n_q;
	logic [DenW-1:0] d_q;
	logic [DenW-1:0] r_q;
	logic [QW-1:0] q_q;
	logic ovf_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DenW-1:0] r2;
	logic ge;

	// restoring division, one quotient bit per cycle
	assign r2 = {r_q[DenW-2:0], n_q[NumW-1]};
	assign ge = (r2 >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CntW'(NumW);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != CntW'(1));
			done_q <= (cnt_q == CntW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n;
			d_q   <= d;
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			n_q   <= {n_q[NumW-2:0], 1'b0};
			r_q   <= ge ? (r2 - d_q) : r2;
			q_q   <= {q_q[QW-2:0], ge};
			ovf_q <= ovf_q | q_q[QW-1];
		end
	end

	assign done = done_q;
	assign q    = q_q;
	assign ovf  = ovf_q;

endmodule

@@ hw/rtl/ste_tan.sv @@
module ste_tan (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  ste_pkg::diff_vec_t dir,
	input  ste_pkg::diff_vec_t chord,
	input  logic [ste_pkg::ScaleW-1:0] scale,
	output logic done,
	output ste_pkg::coord_vec_t tan
);
	import ste_pkg::*;

	tan_state_t st_q, st_d;

	diff_vec_t dir_q;
	diff_vec_t chord_q;
	logic [ScaleW-1:0] scale_q;
	logic side_q;
	logic [1:0] comp_q;
	logic [SumW-1:0] sum_q;
	logic [RootW-1:0] ld_q;
	logic [RootW-1:0] lc_q;
	logic [MulAW-1:0] a_q;
	logic [NumW-1:0] num_q;
	coord_vec_t t_q;

	logic mul_start;
	logic [MulAW-1:0] mul_a;
	logic [MulBW-1:0] mul_b;
	logic mul_done;
	logic [ProdW-1:0] mul_p;
	logic sq_start;
	logic [2*RootW-1:0] sq_s;
	logic sq_done;
	logic [RootW-1:0] sq_root;
	logic dv_start;
	logic [NumW-1:0] dv_n;
	logic [DenW-1:0] dv_d;
	logic dv_done;
	logic [QW-1:0] dv_q;
	logic dv_ovf;
	logic [DiffW-1:0] sel_vec;

	function automatic logic [DiffW-1:0] mag(input logic [DiffW-1:0] v);
		return v[DiffW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [CoordW-1:0] sat_tan(input logic [QW-1:0] qv, input logic of,
			input logic neg);
		if (neg) begin
			if (of || qv[QW-1] || (qv[QW-2] && (|qv[QW-3:0])))
				return TanMin;
			return ~qv[CoordW-1:0] + 1'b1;
		end
		if (of || qv[QW-1] || qv[QW-2])
			return TanMax;
		return qv[CoordW-1:0];
	endfunction

	ste_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	ste_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .s(sq_s),
		.done(sq_done), .root(sq_root)
	);

	ste_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .n(dv_n), .d(dv_d),
		.done(dv_done), .q(dv_q), .ovf(dv_ovf)
	);

	assign sel_vec = side_q ? chord_q[comp_q] : dir_q[comp_q];

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			TS_IDLE:    if (start) st_d = TS_SQ_GO;
			TS_SQ_GO:   st_d = TS_SQ_WAIT;
			TS_SQ_WAIT: if (mul_done) st_d = (comp_q == CompLast) ? TS_RT_GO : TS_SQ_GO;
			TS_RT_GO:   st_d = TS_RT_WAIT;
			TS_RT_WAIT: begin
				if (sq_done) begin
					if (side_q) st_d = TS_MA_GO;
					else if (sq_root == '0) st_d = TS_DONE;
					else st_d = TS_SQ_GO;
				end
			end
			TS_MA_GO:   st_d = TS_MA_WAIT;
			TS_MA_WAIT: if (mul_done) st_d = TS_MS_GO;
			TS_MS_GO:   st_d = TS_MS_WAIT;
			TS_MS_WAIT: if (mul_done) st_d = TS_DV_GO;
			TS_DV_GO:   st_d = TS_DV_WAIT;
			TS_DV_WAIT: if (dv_done) st_d = (comp_q == CompLast) ? TS_DONE : TS_MA_GO;
			TS_DONE:    st_d = TS_IDLE;
			default:    st_d = TS_IDLE;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (st_q)
			TS_SQ_GO: begin
				mul_start = 1'b1;
				mul_a     = MulAW'(mag(sel_vec));
				mul_b     = MulBW'(mag(sel_vec));
			end
			TS_MA_GO: begin
				mul_start = 1'b1;
				mul_a     = MulAW'(mag(dir_q[comp_q]));
				mul_b     = lc_q;
			end
			TS_MS_GO: begin
				mul_start = 1'b1;
				mul_a     = a_q;
				mul_b     = MulBW'(scale_q);
			end
			default: ;
		endcase
		sq_start = (st_q == TS_RT_GO);
		sq_s     = (2*RootW)'(sum_q);
		dv_start = (st_q == TS_DV_GO);
		dv_n     = num_q;
		dv_d     = DenW'({ld_q, ScaleFrac'(0)});
		done     = (st_q == TS_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= TS_IDLE;
			side_q <= 1'b0;
			comp_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == TS_IDLE && start) begin
				side_q <= 1'b0;
				comp_q <= '0;
			end else if (st_q == TS_SQ_WAIT && mul_done) begin
				comp_q <= (comp_q == CompLast) ? 2'd0 : comp_q + 1'b1;
			end else if (st_q == TS_RT_WAIT && sq_done) begin
				side_q <= 1'b1;
				comp_q <= '0;
			end else if (st_q == TS_DV_WAIT && dv_done) begin
				comp_q <= (comp_q == CompLast) ? 2'd0 : comp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == TS_IDLE && start) begin
			dir_q   <= dir;
			chord_q <= chord;
			scale_q <= scale;
			sum_q   <= '0;
		end
		if (st_q == TS_SQ_WAIT && mul_done)
			sum_q <= sum_q + mul_p[SumW-1:0];
		if (st_q == TS_RT_WAIT && sq_done) begin
			sum_q <= '0;
			if (side_q) begin
				lc_q <= sq_root;
			end else begin
				ld_q <= sq_root;
				t_q  <= '0;
			end
		end
		if (st_q == TS_MA_WAIT && mul_done)
			a_q <= mul_p[MulAW-1:0];
		// add half the divisor for round to nearest
		if (st_q == TS_MS_WAIT && mul_done)
			num_q <= mul_p + NumW'({ld_q, (ScaleFrac-1)'(0)});
		if (st_q == TS_DV_WAIT && dv_done)
			t_q[comp_q] <= sat_tan(dv_q, dv_ovf, dir_q[comp_q][DiffW-1]);
	end

	assign tan = t_q;

endmodule

@@ hw/rtl/spline_tangent_estimator_core.sv @@
// channel   direction  payload    handshake
// pt        in         pt_req_t   pt_valid / pt_stall
// res       out        tan_res_t  res_valid / res_stall
// cfg       in         apb        psel penable pwrite paddr pwdata prdata pready
//
// one request at a time; each result needs up to two tangents, each worked out
// by the shared bit-serial multiplier, square root and divider
// a request gives up to three results
// a tangent along a zero direction ends after the first square root
// arst_n clears control, config goes to open loop and scale 1.0
// res_stall holds a finished result; the next one waits behind it
`include "spline_tangent_estimator_core_macros.svh"

module spline_tangent_estimator_core #(
	parameter int MAX_POINTS = ste_pkg::MaxPoints
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ste_pkg::AddrW-1:0] paddr,
	input  logic [ste_pkg::CfgDataW-1:0] pwdata,
	output logic [ste_pkg::CfgDataW-1:0] prdata,
	output logic pready,
	input  logic pt_valid,
	output logic pt_stall,
	input  ste_pkg::pt_req_t pt,
	output logic res_valid,
	input  logic res_stall,
	output ste_pkg::tan_res_t res
);
	import ste_pkg::*;

	localparam int IdxW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
	localparam logic [IdxW-1:0] IdxLast = IdxW'(MAX_POINTS - 1);

	core_state_t state_q, state_d;

	logic closed_q;
	logic [ScaleW-1:0] scale_q;
	coord_vec_t cur_q, first_q, second_q, bh_q, held_q;
	logic cur_last_q;
	coord_vec_t vp_q, vq_q, vn_q;
	coord_vec_t tin_q, tout_q;
	logic [1:0] fill_q;
	logic [IdxW-1:0] idx_q;
	logic [JobCount-1:0] jobs_q, jobs_init;
	job_t job_sel, job_q;
	logic zin_q, zout_q;
	logic [IdxW-1:0] ridx_q;
	logic rdone_q;
	tan_res_t res_q;
	logic res_valid_q;

	coord_vec_t sel_p, sel_q, sel_n;
	logic sel_zin, sel_zout, sel_done;
	logic [IdxW-1:0] sel_idx, prev_idx;
	logic [IdxW+IdxOutW-1:0] ridx_ext;

	logic tan_start, tan_done;
	diff_vec_t tan_dir, tan_chord;
	coord_vec_t tan_t;
	logic slot_free, emit_go, cfg_wr;

	function automatic diff_vec_t vec_diff(input coord_vec_t a, input coord_vec_t b);
		diff_vec_t d;
		for (int c = 0; c < 3; c++)
			d[c] = {a[c][CoordW-1], a[c]} - {b[c][CoordW-1], b[c]};
		return d;
	endfunction

	// config registers
	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
			scale_q  <= ScaleReset;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				RegClosed: closed_q <= pwdata[0];
				RegScale:  scale_q  <= pwdata[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			RegClosed: prdata = CfgDataW'(closed_q);
			RegScale:  prdata = CfgDataW'(scale_q);
			default: ;
		endcase
	end

	// results owed by the incoming point
	always_comb begin
		jobs_init = '0;
		jobs_init[JOB_INT] = fill_q[1];
		if (pt.last_point) begin
			if (fill_q == 2'd0) begin
				jobs_init[JOB_LONE] = 1'b1;
			end else if (closed_q) begin
				jobs_init[JOB_CW1] = 1'b1;
				jobs_init[JOB_CW2] = 1'b1;
			end else begin
				jobs_init[JOB_OPEN0] = (fill_q == 2'd1);
				jobs_init[JOB_OPENE] = 1'b1;
			end
		end else begin
			jobs_init[JOB_OPEN0] = (fill_q == 2'd1) && !closed_q;
		end
	end

	always_comb begin
		job_sel = JOB_INT;
		for (int i = JobCount - 1; i >= 0; i--)
			if (jobs_q[i]) job_sel = job_t'(i);
	end

	assign prev_idx = (idx_q == '0) ? IdxLast : idx_q - 1'b1;

	always_comb begin
		sel_p    = held_q;
		sel_q    = cur_q;
		sel_n    = cur_q;
		sel_zin  = 1'b0;
		sel_zout = 1'b0;
		sel_idx  = idx_q;
		sel_done = 1'b0;
		unique case (job_sel)
			JOB_INT: begin
				sel_p   = bh_q;
				sel_q   = held_q;
				sel_idx = prev_idx;
			end
			JOB_LONE: begin
				sel_zin  = 1'b1;
				sel_zout = 1'b1;
				sel_done = 1'b1;
			end
			JOB_CW1: begin
				sel_n = first_q;
			end
			JOB_CW2: begin
				sel_p    = cur_q;
				sel_q    = first_q;
				sel_n    = fill_q[1] ? second_q : cur_q;
				sel_idx  = '0;
				sel_done = 1'b1;
			end
			JOB_OPEN0: begin
				sel_p   = first_q;
				sel_q   = first_q;
				sel_zin = 1'b1;
				sel_idx = '0;
			end
			JOB_OPENE: begin
				sel_zout = 1'b1;
				sel_done = 1'b1;
			end
			default: ;
		endcase
	end

	assign tan_dir   = vec_diff(vn_q, vp_q);
	assign tan_chord = (state_q == ST_OUT_GO) ? vec_diff(vn_q, vq_q) : vec_diff(vq_q, vp_q);
	assign slot_free = !res_valid_q || !res_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (pt_valid) state_d = ST_PICK;
			ST_PICK:     state_d = (jobs_q == '0) ? ST_UPDATE : ST_IN_GO;
			ST_IN_GO:    state_d = zin_q ? ST_OUT_GO : ST_IN_WAIT;
			ST_IN_WAIT:  if (tan_done) state_d = ST_OUT_GO;
			ST_OUT_GO:   state_d = zout_q ? ST_EMIT : ST_OUT_WAIT;
			ST_OUT_WAIT: if (tan_done) state_d = ST_EMIT;
			ST_EMIT:     if (slot_free) state_d = ST_PICK;
			ST_UPDATE:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pt_stall  = (state_q != ST_IDLE);
		tan_start = (state_q == ST_IN_GO && !zin_q) || (state_q == ST_OUT_GO && !zout_q);
		emit_go   = (state_q == ST_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			jobs_q      <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && pt_valid)
				jobs_q <= jobs_init;
			else if (emit_go)
				jobs_q[job_q] <= 1'b0;
			if (state_q == ST_UPDATE) begin
				if (cur_last_q) begin
					fill_q <= '0;
					idx_q  <= '0;
				end else begin
					fill_q <= fill_q[1] ? fill_q : fill_q + 1'b1;
					idx_q  <= (idx_q == IdxLast) ? '0 : idx_q + 1'b1;
				end
			end
			if (emit_go)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && pt_valid) begin
			cur_q[0]   <= pt.pos_x;
			cur_q[1]   <= pt.pos_y;
			cur_q[2]   <= pt.pos_z;
			cur_last_q <= pt.last_point;
		end
		if (state_q == ST_PICK) begin
			vp_q    <= sel_p;
			vq_q    <= sel_q;
			vn_q    <= sel_n;
			zin_q   <= sel_zin;
			zout_q  <= sel_zout;
			ridx_q  <= sel_idx;
			rdone_q <= sel_done;
			job_q   <= job_sel;
			tin_q   <= '0;
			tout_q  <= '0;
		end
		if (state_q == ST_IN_WAIT && tan_done)
			tin_q <= tan_t;
		if (state_q == ST_OUT_WAIT && tan_done)
			tout_q <= tan_t;
		if (state_q == ST_UPDATE && !cur_last_q) begin
			if (fill_q == 2'd0)
				first_q <= cur_q;
			if (fill_q == 2'd1)
				second_q <= cur_q;
			bh_q   <= held_q;
			held_q <= cur_q;
		end
		if (emit_go) begin
			res_q.point_index <= ridx_ext[IdxOutW-1:0];
			res_q.in_tan_x    <= tin_q[0];
			res_q.in_tan_y    <= tin_q[1];
			res_q.in_tan_z    <= tin_q[2];
			res_q.out_tan_x   <= tout_q[0];
			res_q.out_tan_y   <= tout_q[1];
			res_q.out_tan_z   <= tout_q[2];
			res_q.run_done    <= rdone_q;
		end
	end

	assign ridx_ext  = {IdxOutW'(0), ridx_q};
	assign res_valid = res_valid_q;
	assign res       = res_q;

	ste_tan u_tan (
		.clk(clk), .arst_n(arst_n), .start(tan_start), .dir(tan_dir), .chord(tan_chord),
		.scale(scale_q), .done(tan_done), .tan(tan_t)
	);

	`STE_ASSERT_NEXT(a_emit_hold, state_q == ST_EMIT && res_valid_q && res_stall, state_q == ST_EMIT, "result overwritten while stalled")
	`STE_ASSERT_IMPLY(a_update_clear, state_q == ST_UPDATE, jobs_q == '0, "point state updated with results owed")
	`STE_ASSERT_IMPLY(a_tan_wait, tan_done, state_q == ST_IN_WAIT || state_q == ST_OUT_WAIT, "tangent finished outside a wait")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

class tangent_scoreboard;
	bit closed;
	bit [15:0] scale;
	logic signed [63:0] first_pt[3], second_pt[3], prev_pt[3], held_pt[3];
	bit [15:0] next_idx;
	int fill;
	ste_pkg::tan_res_t expected_q[$];
	int errors;

	function new();
		closed = 0;
		scale = 16'd256;
		foreach (first_pt[c]) begin
			first_pt[c] = 0;
			second_pt[c] = 0;
			prev_pt[c] = 0;
			held_pt[c] = 0;
		end
		next_idx = 0;
		fill = 0;
		errors = 0;
	endfunction

	static function bit [127:0] root(bit [127:0] s);
		bit [127:0] r, c;
		r = 0;
		for (int b = 35; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= s) r = c;
		end
		return r;
	endfunction

	function void tangent(input logic signed [63:0] d[3], input logic signed [63:0] ch[3],
			output logic [31:0] t[3]);
		bit [127:0] sd, sc, ld, lc, den, n, q, m;
		sd = 0;
		sc = 0;
		for (int c = 0; c < 3; c++) begin
			m = d[c] < 0 ? 128'(-d[c]) : 128'(d[c]);
			sd += m * m;
			m = ch[c] < 0 ? 128'(-ch[c]) : 128'(ch[c]);
			sc += m * m;
		end
		ld = root(sd);
		lc = root(sc);
		for (int c = 0; c < 3; c++) begin
			if (ld == 0) begin
				t[c] = 0;
				continue;
			end
			den = ld << 8;
			m = d[c] < 0 ? 128'(-d[c]) : 128'(d[c]);
			n = m * lc * 128'(scale);
			q = (n + (den >> 1)) / den;
			if (d[c] < 0) begin
				if (q > 128'h8000_0000) q = 128'h8000_0000;
				t[c] = 32'(-q);
			end else begin
				if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
				t[c] = q[31:0];
			end
		end
	endfunction

	function void push(bit [15:0] idx, logic [31:0] ti[3], logic [31:0] to[3], bit done);
		ste_pkg::tan_res_t r;
		r.point_index = idx;
		r.in_tan_x = ti[0];
		r.in_tan_y = ti[1];
		r.in_tan_z = ti[2];
		r.out_tan_x = to[0];
		r.out_tan_y = to[1];
		r.out_tan_z = to[2];
		r.run_done = done;
		expected_q.push_back(r);
	endfunction

	function void both_sides(input logic signed [63:0] p[3], input logic signed [63:0] q[3],
			input logic signed [63:0] nx[3], output logic [31:0] ti[3],
			output logic [31:0] to[3]);
		logic signed [63:0] d[3], ci[3], co[3];
		for (int c = 0; c < 3; c++) begin
			d[c] = nx[c] - p[c];
			ci[c] = q[c] - p[c];
			co[c] = nx[c] - q[c];
		end
		tangent(d, ci, ti);
		tangent(d, co, to);
	endfunction

	function void one_side(input logic signed [63:0] a[3], input logic signed [63:0] b[3],
			output logic [31:0] t[3]);
		logic signed [63:0] d[3];
		for (int c = 0; c < 3; c++) d[c] = b[c] - a[c];
		tangent(d, d, t);
	endfunction

	function void note_point(ste_pkg::pt_req_t p);
		logic signed [63:0] cur[3];
		logic [31:0] ti[3], to[3], zero[3];
		bit [15:0] idx;
		idx = next_idx;
		cur[0] = 64'(p.pos_x);
		cur[1] = 64'(p.pos_y);
		cur[2] = 64'(p.pos_z);
		foreach (zero[c]) zero[c] = 0;
		if (fill >= 2) begin
			both_sides(prev_pt, held_pt, cur, ti, to);
			push(idx - 16'd1, ti, to, 0);
		end
		if (p.last_point) begin
			if (fill == 0) begin
				push(idx, zero, zero, 1);
			end else if (closed) begin
				both_sides(held_pt, cur, first_pt, ti, to);
				push(idx, ti, to, 0);
				both_sides(cur, first_pt, fill >= 2 ? second_pt : cur, ti, to);
				push(0, ti, to, 1);
			end else begin
				if (fill == 1) begin
					one_side(first_pt, cur, to);
					push(0, zero, to, 0);
				end
				one_side(held_pt, cur, ti);
				push(idx, ti, zero, 1);
			end
			fill = 0;
			next_idx = 0;
			return;
		end
		if (fill == 0) begin
			first_pt = cur;
		end else if (fill == 1) begin
			second_pt = cur;
			if (!closed) begin
				one_side(first_pt, cur, to);
				push(0, zero, to, 0);
			end
		end
		prev_pt = held_pt;
		held_pt = cur;
		if (fill < 2) fill++;
		next_idx = idx + 16'd1;
	endfunction

	function void check_result(ste_pkg::tan_res_t a);
		ste_pkg::tan_res_t e;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result %h", $time, a);
			errors++;
			return;
		end
		e = expected_q.pop_front();
		if (a.point_index !== e.point_index || a.run_done !== e.run_done ||
				a.in_tan_x !== e.in_tan_x || a.in_tan_y !== e.in_tan_y ||
				a.in_tan_z !== e.in_tan_z || a.out_tan_x !== e.out_tan_x ||
				a.out_tan_y !== e.out_tan_y || a.out_tan_z !== e.out_tan_z) begin
			$display("%0t: mismatch idx exp %0d act %0d done exp %0d act %0d", $time,
				e.point_index, a.point_index, e.run_done, a.run_done);
			$display("  in  exp %h %h %h act %h %h %h", e.in_tan_x, e.in_tan_y,
				e.in_tan_z, a.in_tan_x, a.in_tan_y, a.in_tan_z);
			$display("  out exp %h %h %h act %h %h %h", e.out_tan_x, e.out_tan_y,
				e.out_tan_z, a.out_tan_x, a.out_tan_y, a.out_tan_z);
			errors++;
		end
	endfunction
endclass

module testbench;
	import ste_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [AddrW-1:0] paddr = '0;
	logic [CfgDataW-1:0] pwdata = '0;
	logic [CfgDataW-1:0] prdata;
	logic pready;
	logic pt_valid = 0;
	logic pt_stall;
	pt_req_t pt = '0;
	logic res_valid;
	logic res_stall = 0;
	tan_res_t res;

	tangent_scoreboard sb = new();
	bit quiet = 0;
	int stall_left = 0;

	spline_tangent_estimator_core u_dut (.*);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		if (arst_n && pt_valid && !pt_stall) sb.note_point(pt);
		if (arst_n && res_valid && !res_stall) sb.check_result(res);
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 4);
			res_stall <= 1;
		end else begin
			res_stall <= 0;
		end
	end

	task automatic write_reg(logic [AddrW-1:0] addr, logic [31:0] val);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == AddrW'(RegClosed) << 2) sb.closed = val[0];
		else sb.scale = val[15:0];
	endtask

	task automatic drain();
		pt_valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (6000) @(posedge clk);
	endtask

	task automatic set_mode(bit cl, logic [15:0] sc);
		drain();
		write_reg(AddrW'(RegClosed) << 2, 32'(cl));
		write_reg(AddrW'(RegScale) << 2, 32'(sc));
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit last);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			pt_valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		pt <= '{pos_x: x, pos_y: y, pos_z: z, last_point: last};
		pt_valid <= 1;
		do @(negedge clk); while (pt_stall);
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 2000)) - 32'd1000;
			1: return $urandom;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return 32'($urandom_range(0, 1 << 20)) - 32'd524288;
		endcase
	endfunction

	task automatic corner_runs();
		send_point(32'd100, 32'd200, 32'd300, 1);
		send_point(32'd0, 32'd0, 32'd0, 0);
		send_point(32'd256, 32'd512, -32'd768, 1);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		send_point(32'd5, 32'd5, 32'd5, 0);
		send_point(32'd9, 32'd9, 32'd9, 0);
		send_point(32'd5, 32'd5, 32'd5, 1);
	endtask

	initial begin
		int sent, len;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		corner_runs();
		set_mode(1, 16'd256);
		corner_runs();
		set_mode(0, 16'd0);
		send_point(32'd10, 32'd20, 32'd30, 0);
		send_point(32'd40, 32'd20, -32'd30, 1);
		set_mode(1, 16'hFFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_point(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 0);
		send_point(32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		sent = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_mode(0, 16'd256);
				1: set_mode(1, 16'($urandom));
				2: set_mode(0, 16'hFFFF);
				3: set_mode(1, 16'd0);
				4: set_mode($urandom_range(0, 1), 16'($urandom_range(1, 1024)));
				default: begin
					set_mode(1, 16'd256);
					quiet = 1;
				end
			endcase
			while (sent < (ph + 1) * 72) begin
				len = $urandom_range(0, 9) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 7) == 0 && i > 0)
						send_point(pt.pos_x, pt.pos_y, pt.pos_z, i == len - 1);
					else
						send_point(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
					sent++;
				end
			end
		end
		drain();
		if (sb.errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#400ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ste_pkg.sv
hw/rtl/ste_mul.sv
hw/rtl/ste_sqrt.sv
hw/rtl/ste_div.sv
hw/rtl/ste_tan.sv
hw/rtl/spline_tangent_estimator_core.sv
tb/testbench.sv
